// ----- design/uwt_pkg.sv -----
// Shared constants and types for the card identifier whitelist table.
package uwt_pkg;

    localparam int CAPACITY   = 16;
    localparam int ID_W       = 32;
    localparam int MODE_W     = 2;
    localparam int ENTRY_CNT_W = 5;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [MODE_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_STORE  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic load;     // capture the input item
        logic compare;  // register the match vector
        logic commit;   // update table and count, write the result register
    } uwt_cmd_t;

endpackage

// ----- design/uwt_ctrl.sv -----
// Controller state machine sequencing load, compare and commit steps.
module uwt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output uwt_pkg::uwt_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // The result register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_UPD) && slot_free);

    assign cmd.load    = in_valid && in_ready;
    assign cmd.compare = (state_reg == ST_CMP);
    assign cmd.commit  = (state_reg == ST_UPD) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (slot_free)
                begin
                    state_next = cmd.load ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- design/uwt_dpath.sv -----
// Datapath: identifier table registers, parallel compare, compaction and result register.
module uwt_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  uwt_pkg::uwt_cmd_t                    cmd,
    input  logic [uwt_pkg::MODE_W-1:0]           mode,
    input  logic [uwt_pkg::ID_W-1:0]             card_id,
    output logic                                 hit,
    output logic                                 status,
    output logic [uwt_pkg::ENTRY_CNT_W-1:0]      entry_count
);

    logic [uwt_pkg::MODE_W-1:0]      mode_reg;
    logic [uwt_pkg::ID_W-1:0]        id_reg;
    logic [uwt_pkg::ID_W-1:0]        table_reg [uwt_pkg::CAPACITY];
    logic [uwt_pkg::COUNT_W-1:0]     count_reg;
    logic [uwt_pkg::COUNT_W-1:0]     count_next;
    logic [uwt_pkg::CAPACITY-1:0]    match_reg;
    logic [uwt_pkg::CAPACITY-1:0]    match_next;
    logic [uwt_pkg::CAPACITY-1:0]    first_oh;
    logic [uwt_pkg::CAPACITY-1:0]    shift_mask;
    logic                            any_match;
    logic                            full;
    logic                            hit_next;
    logic                            status_next;
    logic                            hit_reg;
    logic                            status_reg;
    logic [uwt_pkg::ENTRY_CNT_W-1:0] entry_count_reg;
    uwt_pkg::op_t                    op;

    assign op   = uwt_pkg::op_t'(mode_reg);
    assign full = (count_reg == uwt_pkg::COUNT_W'(uwt_pkg::CAPACITY));

    // Compare every live entry against the key at once.
    always_comb
    begin
        for (int k = 0; k < uwt_pkg::CAPACITY; k++)
        begin
            match_next[k] = (uwt_pkg::COUNT_W'(k) < count_reg) && (table_reg[k] == id_reg);
        end
    end

    // Isolate the first match; every entry from there on moves up one place.
    assign first_oh   = match_reg & (~match_reg + uwt_pkg::CAPACITY'(1));
    assign shift_mask = ~(first_oh - uwt_pkg::CAPACITY'(1));
    assign any_match  = |match_reg;

    always_comb
    begin
        count_next  = count_reg;
        hit_next    = 1'b0;
        status_next = 1'b0;
        unique case (op)
            uwt_pkg::OP_LOOKUP:
            begin
                hit_next = any_match;
            end
            uwt_pkg::OP_STORE:
            begin
                if (full)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + uwt_pkg::COUNT_W'(1);
                end
            end
            uwt_pkg::OP_REMOVE:
            begin
                if (any_match)
                begin
                    hit_next   = 1'b1;
                    count_next = count_reg - uwt_pkg::COUNT_W'(1);
                end
            end
            uwt_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            id_reg   <= card_id;
        end
        if (cmd.compare)
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if ((op == uwt_pkg::OP_REMOVE) && any_match)
            begin
                for (int k = 0; k < uwt_pkg::CAPACITY - 1; k++)
                begin
                    if (shift_mask[k])
                    begin
                        table_reg[k] <= table_reg[k + 1];
                    end
                end
            end
            else if ((op == uwt_pkg::OP_STORE) && !full)
            begin
                table_reg[count_reg[uwt_pkg::IDX_W-1:0]] <= id_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg         <= hit_next;
            status_reg      <= status_next;
            entry_count_reg <= uwt_pkg::ENTRY_CNT_W'(count_next);
        end
    end

    assign hit         = hit_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

// ----- design/uid_whitelist_table.sv -----
// Top level of the card identifier whitelist table.
//
// A packed table of up to 16 32-bit card identifiers with a fill count.
// Each input transfer carries a mode and a card_id: lookup (0) sets hit when
// any stored entry equals card_id; store (1) appends card_id when the table
// is not full (no duplicate check) and otherwise sets status to flag the
// table full; remove (2) deletes the first matching entry, moves the later
// entries up one place and sets hit; clear (3) empties the table. Every
// input transfer gives exactly one output transfer that also carries the
// entry_count after the operation. Once accepted, an item passes through
// a compare step that registers the parallel compare of all live entries
// and a commit step that updates the table and the result register.
// A new item is taken during the commit step of the one before. The
// result register holds a finished result while the next item is already
// in compare; only a result still unclaimed at the next commit stalls the
// block. Table contents are not cleared by reset or by clear; only the
// fill count is, and entries at or beyond it are never compared.
module uid_whitelist_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [uwt_pkg::MODE_W-1:0]          mode,
    input  logic [uwt_pkg::ID_W-1:0]            card_id,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic                                status,
    output logic [uwt_pkg::ENTRY_CNT_W-1:0]     entry_count
);

    uwt_pkg::uwt_cmd_t cmd;

    // Sequence each transfer through load, compare and commit.
    uwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Hold the table, the count and the result register.
    uwt_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .card_id     (card_id),
        .hit         (hit),
        .status      (status),
        .entry_count (entry_count)
    );

endmodule

// ----- design/uwt_checker.sv -----
// Port-level checker for the whitelist table and its bind to the top level.
module uwt_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                hit,
    input  logic                                status,
    input  logic [uwt_pkg::ENTRY_CNT_W-1:0]     entry_count
);

    // No result can be pending once reset has been applied.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result pending during reset");

    // An input transfer is followed by a compare step, during which no input is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken during compare");

    // The count never exceeds the table capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= uwt_pkg::ENTRY_CNT_W'(uwt_pkg::CAPACITY)))
        else $error("entry_count above capacity");

    // A refused store reports a full table and no hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |->
            (!hit && (entry_count == uwt_pkg::ENTRY_CNT_W'(uwt_pkg::CAPACITY))))
        else $error("full flag inconsistent with count or hit");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(hit) && $stable(status) && $stable(entry_count)))
        else $error("stalled result changed");

endmodule

bind uid_whitelist_table uwt_checker u_uwt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .status      (status),
    .entry_count (entry_count)
);
